// File: src/ffa_pkg.sv
// shared types, constants and command codes of the first-fit heap allocator
// no dependencies
package ffa_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 12;
   localparam int MIN_HEAP     = 4096;
   localparam int HEAP_WORDS   = HEAP_BYTES / 4;
   localparam int WIDX_W       = $clog2(HEAP_WORDS);
   localparam int BADDR_W      = $clog2(HEAP_BYTES);

   typedef logic [1:0]  op_type;
   typedef logic [16:0] hsize_type;
   typedef logic [31:0] word_type;
   typedef logic [15:0] offset_type;
   typedef logic [1:0]  stat_code_type;
   typedef logic [33:0] addr_type;
   typedef logic [17:0] need_type;
   typedef logic [WIDX_W-1:0] widx_type;

   localparam op_type OP_ALLOC  = 2'd0;
   localparam op_type OP_FREE   = 2'd1;
   localparam op_type OP_LOCATE = 2'd2;

   localparam stat_code_type ST_OK      = 2'd0;
   localparam stat_code_type ST_REJECT  = 2'd1;
   localparam stat_code_type ST_IGNORED = 2'd2;
   localparam stat_code_type ST_CORRUPT = 2'd3;

   typedef enum logic [5:0] {
      CMD_NONE,
      CMD_CLR,
      CMD_INIT0,
      CMD_INIT1,
      CMD_INIT2,
      CMD_ACCEPT,
      CMD_RD_M0,
      CMD_RD_M4,
      CMD_RD_M8,
      CMD_RD_P0,
      CMD_RD_P8,
      CMD_RD_N0,
      CMD_RD_N4,
      CMD_RD_N8,
      CMD_CAP_OWN,
      CMD_CAP_NX,
      CMD_CAP_PREV,
      CMD_CAP_NEXT,
      CMD_ADV,
      CMD_TAKE,
      CMD_WR_ZERO,
      CMD_WR_M0_NEED,
      CMD_WR_R8,
      CMD_WR_R0,
      CMD_WR_R4,
      CMD_WR_T4,
      CMD_F_MEM,
      CMD_F_PM,
      CMD_JOIN_P,
      CMD_WR_N4,
      CMD_JOIN_N,
      CMD_WR_A4,
      CMD_FREE_END,
      CMD_SET_ST1,
      CMD_SET_ST2,
      CMD_SET_ST3,
      CMD_SET_HS,
      CMD_SET_RES12,
      CMD_SET_RESMEM
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   init_pend;
      logic   clr_done;
      logic   a_bad;
      logic   a_zero;
      logic   f_bad;
      logic   l_bad;
      logic   mem_end;
      logic   nx_fits;
      logic   nx_zero;
      logic   split;
      logic   after_in;
      logic   zero_done;
      logic   loc_hit;
      logic   loc_hdr;
      logic   prev_zero;
      logic   prev_gt_mem;
      logic   pnext_bad;
      logic   own_zero;
      logic   nxt_bad;
      logic   nxt_not_end;
      logic   nprev_bad;
      logic   after_not_end;
   } dp_stat_type;

endpackage

// File: src/ffa_if.sv
// request and response channel interfaces of the first-fit heap allocator
// depends on ffa_pkg
interface ffa_req_if;
   logic                valid;
   logic                ready;
   ffa_pkg::op_type     op;
   ffa_pkg::hsize_type  size;
   ffa_pkg::word_type   owner_id;
   ffa_pkg::offset_type offset;

   modport source (output valid, op, size, owner_id, offset, input ready);
   modport sink (input valid, op, size, owner_id, offset, output ready);
endinterface

interface ffa_rsp_if;
   logic                   valid;
   logic                   ready;
   ffa_pkg::hsize_type     result_offset;
   ffa_pkg::stat_code_type status;

   modport source (output valid, result_offset, status, input ready);
   modport sink (input valid, result_offset, status, output ready);
endinterface

// File: src/ffa_dpath.sv
// datapath of the first-fit heap allocator: heap memory, chunk registers, flags
// depends on ffa_pkg; driven by ffa_ctrl through cmd_type commands
module ffa_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  ffa_pkg::cmd_type       cmd,
   input  logic                   csr_we,
   input  ffa_pkg::hsize_type     csr_wdata,
   input  ffa_pkg::op_type        req_op,
   input  ffa_pkg::hsize_type     req_size,
   input  ffa_pkg::word_type      req_owner_id,
   input  ffa_pkg::offset_type    req_offset,
   output ffa_pkg::dp_stat_type   stat,
   output ffa_pkg::hsize_type     rsp_result_offset,
   output ffa_pkg::stat_code_type rsp_status
);
   import ffa_pkg::*;

   word_type      ram [HEAP_WORDS];
   word_type      ram_q_ff;
   logic          oob_ff;
   word_type      rd_data;

   hsize_type     hs_ff;
   logic          init_pend_ff;
   op_type        op_ff;
   hsize_type     size_ff;
   word_type      id_ff;
   offset_type    off_ff;
   need_type      need_ff;
   addr_type      mem_ff;
   addr_type      ptr_ff;
   addr_type      lim_ff;
   addr_type      nxtat_ff;
   word_type      nx_ff;
   word_type      own_ff;
   word_type      prev_ff;
   word_type      next_ff;
   hsize_type     res_ff;
   stat_code_type st_ff;

   addr_type      hs_x;
   addr_type      mem_need;
   addr_type      mem_nx;
   addr_type      mem_tail;
   addr_type      off_x;
   addr_type      addr;
   word_type      wdata;
   logic          mem_we;
   logic          mem_re;
   logic          addr_oob;
   word_type      rest;
   word_type      join_p;
   word_type      join_n;
   hsize_type     cfg_sat;

   assign hs_x     = addr_type'(hs_ff);
   assign mem_need = mem_ff + addr_type'(need_ff);
   assign mem_nx   = mem_ff + addr_type'(nx_ff);
   assign mem_tail = mem_ff + addr_type'(next_ff);
   assign off_x    = addr_type'(off_ff);
   assign rest     = nx_ff - word_type'(need_ff);
   assign join_p   = prev_ff + next_ff;
   assign join_n   = next_ff + nx_ff;
   assign rd_data  = oob_ff ? '0 : ram_q_ff;
   assign cfg_sat  = (csr_wdata > hsize_type'(HEAP_BYTES)) ? hsize_type'(HEAP_BYTES) : csr_wdata;

   always_comb begin
      addr   = '0;
      wdata  = '0;
      mem_we = 1'b0;
      mem_re = 1'b0;
      case (cmd)
         CMD_CLR:        begin addr = ptr_ff; mem_we = 1'b1; end
         CMD_INIT0:      begin addr = '0; wdata = word_type'(hs_ff); mem_we = 1'b1; end
         CMD_INIT1:      begin addr = addr_type'(4); mem_we = 1'b1; end
         CMD_INIT2:      begin addr = addr_type'(8); mem_we = 1'b1; end
         CMD_RD_M0:      begin addr = mem_ff; mem_re = 1'b1; end
         CMD_RD_M4:      begin addr = mem_ff + addr_type'(4); mem_re = 1'b1; end
         CMD_RD_M8:      begin addr = mem_ff + addr_type'(8); mem_re = 1'b1; end
         CMD_RD_P0:      begin addr = ptr_ff; mem_re = 1'b1; end
         CMD_RD_P8:      begin addr = ptr_ff + addr_type'(8); mem_re = 1'b1; end
         CMD_RD_N0:      begin addr = nxtat_ff; mem_re = 1'b1; end
         CMD_RD_N4:      begin addr = nxtat_ff + addr_type'(4); mem_re = 1'b1; end
         CMD_RD_N8:      begin addr = nxtat_ff + addr_type'(8); mem_re = 1'b1; end
         CMD_TAKE:       begin addr = mem_ff + addr_type'(8); wdata = id_ff; mem_we = 1'b1; end
         CMD_WR_ZERO:    begin addr = ptr_ff; mem_we = 1'b1; end
         CMD_WR_M0_NEED: begin addr = mem_ff; wdata = word_type'(need_ff); mem_we = 1'b1; end
         CMD_WR_R8:      begin addr = mem_need + addr_type'(8); mem_we = 1'b1; end
         CMD_WR_R0:      begin addr = mem_need; wdata = rest; mem_we = 1'b1; end
         CMD_WR_R4:      begin
            addr = mem_need + addr_type'(4); wdata = word_type'(need_ff); mem_we = 1'b1;
         end
         CMD_WR_T4:      begin addr = mem_nx + addr_type'(4); wdata = rest; mem_we = 1'b1; end
         CMD_JOIN_P:     begin addr = ptr_ff; wdata = join_p; mem_we = 1'b1; end
         CMD_WR_N4:      begin addr = nxtat_ff + addr_type'(4); wdata = next_ff; mem_we = 1'b1; end
         CMD_JOIN_N:     begin addr = mem_ff; wdata = join_n; mem_we = 1'b1; end
         CMD_WR_A4:      begin addr = mem_tail + addr_type'(4); wdata = next_ff; mem_we = 1'b1; end
         CMD_FREE_END:   begin addr = mem_ff + addr_type'(8); mem_we = 1'b1; end
         default:        begin addr = '0; end
      endcase
   end

   assign addr_oob = |addr[33:BADDR_W];

   always_ff @(posedge clock) begin
      if (mem_we && !addr_oob) begin
         ram[addr[BADDR_W-1:2]] <= wdata;
      end
      if (mem_re) begin
         ram_q_ff <= ram[addr[BADDR_W-1:2]];
         oob_ff   <= addr_oob;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff        <= hsize_type'(HEAP_BYTES);
         init_pend_ff <= 1'b1;
         ptr_ff       <= '0;
      end else begin
         if (cmd == CMD_INIT2) begin
            init_pend_ff <= 1'b0;
         end
         if (csr_we && csr_wdata >= hsize_type'(MIN_HEAP)) begin
            hs_ff        <= {cfg_sat[16:2], 2'b00};
            init_pend_ff <= 1'b1;
         end
         case (cmd)
            CMD_CLR:     ptr_ff <= ptr_ff + addr_type'(4);
            CMD_WR_ZERO: ptr_ff <= ptr_ff + addr_type'(4);
            CMD_TAKE:    ptr_ff <= mem_ff + addr_type'(HEADER_BYTES);
            CMD_F_PM:    ptr_ff <= mem_ff - addr_type'(prev_ff);
            default:     ptr_ff <= ptr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_ACCEPT: begin
            op_ff   <= req_op;
            size_ff <= req_size;
            id_ff   <= req_owner_id;
            off_ff  <= req_offset;
            need_ff <= (need_type'(req_size) + need_type'(HEADER_BYTES + 3)) & ~need_type'(3);
            mem_ff  <= '0;
            res_ff  <= '0;
            st_ff   <= ST_OK;
         end
         CMD_CAP_OWN:    own_ff <= rd_data;
         CMD_CAP_NX:     nx_ff <= rd_data;
         CMD_CAP_PREV:   prev_ff <= rd_data;
         CMD_CAP_NEXT: begin
            next_ff  <= rd_data;
            nxtat_ff <= mem_ff + addr_type'(rd_data);
         end
         CMD_ADV:        mem_ff <= mem_nx;
         CMD_TAKE:       lim_ff <= mem_need;
         CMD_F_MEM:      mem_ff <= addr_type'(off_ff - offset_type'(HEADER_BYTES));
         CMD_JOIN_P: begin
            mem_ff  <= ptr_ff;
            next_ff <= join_p;
         end
         CMD_JOIN_N:     next_ff <= join_n;
         CMD_SET_ST1:    st_ff <= ST_REJECT;
         CMD_SET_ST2:    st_ff <= ST_IGNORED;
         CMD_SET_ST3:    st_ff <= ST_CORRUPT;
         CMD_SET_HS:     res_ff <= hs_ff;
         CMD_SET_RES12:  res_ff <= hsize_type'(mem_ff + addr_type'(HEADER_BYTES));
         CMD_SET_RESMEM: res_ff <= hsize_type'(mem_ff);
         default:        res_ff <= res_ff;
      endcase
   end

   always_comb begin
      stat               = '0;
      stat.op            = op_ff;
      stat.init_pend     = init_pend_ff;
      stat.clr_done      = ptr_ff >= addr_type'(HEAP_BYTES);
      stat.a_bad         = (id_ff == '0) || (size_ff > hs_ff);
      stat.a_zero        = (size_ff == '0);
      stat.f_bad         = (off_ff < offset_type'(HEADER_BYTES)) ||
                           (hsize_type'(off_ff - offset_type'(HEADER_BYTES)) >= hs_ff);
      stat.l_bad         = hsize_type'(off_ff) >= hs_ff;
      stat.mem_end       = mem_ff >= hs_x;
      stat.nx_fits       = addr_type'(nx_ff) >= addr_type'(need_ff);
      stat.nx_zero       = (nx_ff == '0);
      stat.split         = addr_type'(nx_ff) > addr_type'(need_ff) + addr_type'(HEADER_BYTES);
      stat.after_in      = mem_nx < hs_x;
      stat.zero_done     = ptr_ff >= lim_ff;
      stat.loc_hit       = (off_x >= mem_ff) && (off_x < mem_nx);
      stat.loc_hdr       = (off_x - mem_ff) < addr_type'(HEADER_BYTES);
      stat.prev_zero     = (prev_ff == '0);
      stat.prev_gt_mem   = addr_type'(prev_ff) > mem_ff;
      stat.pnext_bad     = (nx_ff != prev_ff);
      stat.own_zero      = (own_ff == '0);
      stat.nxt_bad       = (nxtat_ff <= mem_ff) || (nxtat_ff > hs_x);
      stat.nxt_not_end   = (nxtat_ff != hs_x);
      stat.nprev_bad     = (nx_ff != next_ff);
      stat.after_not_end = (mem_tail != hs_x);
   end

   assign rsp_result_offset = res_ff;
   assign rsp_status        = st_ff;

   ap_zero_in_chunk: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_WR_ZERO |-> ptr_ff < lim_ff)
      else $error("payload clear ran past its chunk");

   ap_init_clears_pend: assert property (@(posedge clock) disable iff (reset)
      $fell(init_pend_ff) |-> $past(cmd) == CMD_INIT2)
      else $error("heap init flag dropped without header write");

   ap_hs_range: assert property (@(posedge clock) disable iff (reset)
      hs_ff[1:0] == 2'b00 && hs_ff >= hsize_type'(MIN_HEAP) &&
      hs_ff <= hsize_type'(HEAP_BYTES))
      else $error("heap size out of range");

endmodule

// File: src/ffa_ctrl.sv
// controller state machine of the first-fit heap allocator
// depends on ffa_pkg; issues cmd_type commands to ffa_dpath and reads its flags
module ffa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ffa_pkg::dp_stat_type stat,
   output ffa_pkg::cmd_type     cmd
);
   import ffa_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_DISP, S_RESP,
      S_A0, S_AW, S_A1, S_A2, S_A3, S_A4, S_AZ, S_AS, S_AS1, S_AS2, S_AS3, S_AS4, S_AF,
      S_L0, S_LW, S_L1, S_L2,
      S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9, S_F9B, S_F9C,
      S_F10, S_F11, S_F12, S_F13, S_F14, S_F15, S_F16, S_F17, S_FEND
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_done) state_in = S_IDLE;
            else cmd = CMD_CLR;
         end
         S_IDLE: begin
            if (stat.init_pend) begin
               state_in = S_INIT0;
            end else if (req_valid) begin
               cmd = CMD_ACCEPT; state_in = S_DISP;
            end
         end
         S_INIT0: begin cmd = CMD_INIT0; state_in = S_INIT1; end
         S_INIT1: begin cmd = CMD_INIT1; state_in = S_INIT2; end
         S_INIT2: begin cmd = CMD_INIT2; state_in = S_IDLE; end
         S_DISP: begin
            unique case (stat.op)
               OP_ALLOC:  state_in = S_A0;
               OP_FREE:   state_in = S_F0;
               OP_LOCATE: state_in = S_L0;
               default: begin cmd = CMD_SET_ST2; state_in = S_RESP; end
            endcase
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         // allocate
         S_A0: begin
            if (stat.a_bad) begin
               cmd = CMD_SET_ST1; state_in = S_RESP;
            end else if (stat.a_zero) begin
               cmd = CMD_SET_HS; state_in = S_RESP;
            end else begin
               state_in = S_AW;
            end
         end
         S_AW: begin
            if (stat.mem_end) begin
               cmd = CMD_SET_ST1; state_in = S_RESP;
            end else begin
               cmd = CMD_RD_M8; state_in = S_A1;
            end
         end
         S_A1: begin cmd = CMD_CAP_OWN; state_in = S_A2; end
         S_A2: begin cmd = CMD_RD_M0; state_in = S_A3; end
         S_A3: begin cmd = CMD_CAP_NX; state_in = S_A4; end
         S_A4: begin
            if (stat.own_zero && stat.nx_fits) begin
               cmd = CMD_TAKE; state_in = S_AZ;
            end else if (stat.nx_zero) begin
               cmd = CMD_SET_ST1; state_in = S_RESP;
            end else begin
               cmd = CMD_ADV; state_in = S_AW;
            end
         end
         S_AZ: begin
            if (stat.zero_done) state_in = S_AS;
            else cmd = CMD_WR_ZERO;
         end
         S_AS: begin
            if (stat.split) begin
               cmd = CMD_WR_M0_NEED; state_in = S_AS1;
            end else begin
               cmd = CMD_SET_RES12; state_in = S_RESP;
            end
         end
         S_AS1: begin cmd = CMD_WR_R8; state_in = S_AS2; end
         S_AS2: begin cmd = CMD_WR_R0; state_in = S_AS3; end
         S_AS3: begin cmd = CMD_WR_R4; state_in = S_AS4; end
         S_AS4: begin
            if (stat.after_in) cmd = CMD_WR_T4;
            state_in = S_AF;
         end
         S_AF: begin cmd = CMD_SET_RES12; state_in = S_RESP; end
         // locate
         S_L0: begin
            if (stat.l_bad) begin
               cmd = CMD_SET_ST2; state_in = S_RESP;
            end else begin
               state_in = S_LW;
            end
         end
         S_LW: begin
            if (stat.mem_end) begin
               cmd = CMD_SET_ST2; state_in = S_RESP;
            end else begin
               cmd = CMD_RD_M0; state_in = S_L1;
            end
         end
         S_L1: begin cmd = CMD_CAP_NX; state_in = S_L2; end
         S_L2: begin
            if (stat.nx_zero || (stat.loc_hit && stat.loc_hdr)) begin
               cmd = CMD_SET_ST2; state_in = S_RESP;
            end else if (stat.loc_hit) begin
               cmd = CMD_SET_RESMEM; state_in = S_RESP;
            end else begin
               cmd = CMD_ADV; state_in = S_LW;
            end
         end
         // free
         S_F0: begin
            if (stat.f_bad) begin
               cmd = CMD_SET_ST2; state_in = S_RESP;
            end else begin
               cmd = CMD_F_MEM; state_in = S_F1;
            end
         end
         S_F1: begin cmd = CMD_RD_M4; state_in = S_F2; end
         S_F2: begin cmd = CMD_CAP_PREV; state_in = S_F3; end
         S_F3: begin cmd = CMD_RD_M0; state_in = S_F4; end
         S_F4: begin cmd = CMD_CAP_NEXT; state_in = S_F5; end
         S_F5: begin
            if (stat.prev_zero) begin
               state_in = S_F10;
            end else if (stat.prev_gt_mem) begin
               cmd = CMD_SET_ST3; state_in = S_RESP;
            end else begin
               cmd = CMD_F_PM; state_in = S_F6;
            end
         end
         S_F6: begin cmd = CMD_RD_P0; state_in = S_F7; end
         S_F7: begin cmd = CMD_CAP_NX; state_in = S_F8; end
         S_F8: begin
            if (stat.pnext_bad) begin
               cmd = CMD_SET_ST3; state_in = S_RESP;
            end else begin
               cmd = CMD_RD_P8; state_in = S_F9;
            end
         end
         S_F9: begin cmd = CMD_CAP_OWN; state_in = S_F9B; end
         S_F9B: begin
            if (stat.own_zero) begin
               cmd = CMD_JOIN_P; state_in = S_F9C;
            end else begin
               state_in = S_F10;
            end
         end
         S_F9C: begin
            if (stat.nxt_not_end) cmd = CMD_WR_N4;
            state_in = S_F10;
         end
         S_F10: begin
            if (stat.nxt_bad) begin
               cmd = CMD_SET_ST3; state_in = S_RESP;
            end else if (!stat.nxt_not_end) begin
               state_in = S_FEND;
            end else begin
               cmd = CMD_RD_N4; state_in = S_F11;
            end
         end
         S_F11: begin cmd = CMD_CAP_NX; state_in = S_F12; end
         S_F12: begin
            if (stat.nprev_bad) begin
               cmd = CMD_SET_ST3; state_in = S_RESP;
            end else begin
               cmd = CMD_RD_N8; state_in = S_F13;
            end
         end
         S_F13: begin cmd = CMD_CAP_OWN; state_in = S_F14; end
         S_F14: begin
            if (stat.own_zero) begin
               cmd = CMD_RD_N0; state_in = S_F15;
            end else begin
               state_in = S_FEND;
            end
         end
         S_F15: begin cmd = CMD_CAP_NX; state_in = S_F16; end
         S_F16: begin cmd = CMD_JOIN_N; state_in = S_F17; end
         S_F17: begin
            if (stat.after_not_end) cmd = CMD_WR_A4;
            state_in = S_FEND;
         end
         S_FEND: begin cmd = CMD_FREE_END; state_in = S_RESP; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !stat.init_pend;
   assign rsp_valid = (state_ff == S_RESP);

   ap_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      stat.init_pend |-> !req_ready)
      else $error("request taken before heap header written");

   ap_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DISP)
      else $error("accepted transaction not dispatched");

   ap_ready_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while response pending");

endmodule

// File: src/first_fit_heap_allocator_unit.sv
// first-fit boundary-tag heap allocator: allocate, free and locate on a word heap
// req channel carries op, size, owner_id and offset; rsp channel carries
// result_offset and status; csr_we/csr_wdata write the heap size.
// after reset a clearing pass zeroes all 16384 heap words, one per cycle, and
// then writes the single free chunk header; req_ch.ready stays low meanwhile.
// a heap size write rebuilds the header: size word, then prev and owner words.
// one transaction is handled at a time over the single-port heap memory:
// allocate walks the chunks from the head of the heap, takes the first free
// chunk that fits, clears its payload words and splits off the rest when it
// is large enough; free checks the boundary tags and merges the chunk with a
// free neighbour on either side; locate walks the chunks to the one that
// holds the offset.
// the result waits in rsp_ch until it is taken; a stalled receiver holds the
// block and no new request is accepted until the response leaves.
// depends on ffa_pkg, ffa_if, ffa_ctrl and ffa_dpath
module first_fit_heap_allocator_unit (
   input  logic               clock,
   input  logic               reset,
   ffa_req_if.sink            req_ch,
   ffa_rsp_if.source          rsp_ch,
   input  logic               csr_we,
   input  ffa_pkg::hsize_type csr_wdata
);
   import ffa_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffa_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_op            (req_ch.op),
      .req_size          (req_ch.size),
      .req_owner_id      (req_ch.owner_id),
      .req_offset        (req_ch.offset),
      .stat              (stat),
      .rsp_result_offset (rsp_ch.result_offset),
      .rsp_status        (rsp_ch.status)
   );

endmodule

// File: dv/tb_first_fit_heap_allocator_unit.sv
// testbench of first_fit_heap_allocator_unit: directed, config, backpressure and random tests
// keeps a copy of the heap, predicts every response; depends on ffa_pkg, ffa_if and the DUT
module tb_first_fit_heap_allocator_unit;
   import ffa_pkg::*;

   localparam op_type OP_UNDEF = 2'd3;

   typedef struct {
      hsize_type     result_offset;
      stat_code_type status;
   } heap_result_type;

   logic      clock;
   logic      reset;
   logic      csr_we;
   hsize_type csr_wdata;

   ffa_req_if req_ch();
   ffa_rsp_if rsp_ch();

   first_fit_heap_allocator_unit dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   word_type        heap_mem [HEAP_WORDS];
   int unsigned     heap_len;
   heap_result_type pending_results[$];
   int unsigned     live_offsets[$];
   int              error_count = 0;
   int              burst_left = 0;
   int              hold_cycles = 0;
   bit              stall_mode = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #1200000000;
      $display("*** FAILED ***");
      $finish;
   end

   // heap model
   function automatic word_type heap_rd(longint unsigned addr);
      if ((addr >> 2) < HEAP_WORDS) return heap_mem[addr >> 2];
      return 0;
   endfunction

   function automatic void heap_wr(longint unsigned addr, word_type v);
      if ((addr >> 2) < HEAP_WORDS) heap_mem[addr >> 2] = v;
   endfunction

   function automatic void heap_rebuild();
      heap_wr(0, heap_len);
      heap_wr(4, 0);
      heap_wr(8, 0);
   endfunction

   function automatic void heap_size_write(int unsigned v);
      v = v & 32'h1ffff;
      if (v < MIN_HEAP) return;
      if (v > HEAP_BYTES) v = HEAP_BYTES;
      heap_len = v & ~32'd3;
      heap_rebuild();
   endfunction

   function automatic void heap_alloc(hsize_type sz, word_type id,
                                      output hsize_type res, output stat_code_type st);
      longint unsigned mem, a, after;
      word_type        nx, need, rest;
      res = 0;
      st = ST_REJECT;
      if (id == 0 || sz > heap_len) return;
      if (sz == 0) begin
         res = hsize_type'(heap_len);
         st = ST_OK;
         return;
      end
      need = (sz + HEADER_BYTES + 3) & ~32'd3;
      mem = 0;
      while (mem < heap_len) begin
         nx = heap_rd(mem);
         if (heap_rd(mem + 8) == 0 && nx >= need) begin
            heap_wr(mem + 8, id);
            for (a = mem + HEADER_BYTES; a < mem + need; a += 4) heap_wr(a, 0);
            if (longint'(nx) > longint'(need) + HEADER_BYTES) begin
               after = mem + nx;
               rest = nx - need;
               heap_wr(mem, need);
               heap_wr(mem + need + 8, 0);
               heap_wr(mem + need, rest);
               heap_wr(mem + need + 4, need);
               if (after < heap_len) heap_wr(after + 4, rest);
            end
            res = hsize_type'(mem + HEADER_BYTES);
            st = ST_OK;
            return;
         end
         if (nx == 0) break;
         mem += nx;
      end
   endfunction

   function automatic stat_code_type heap_free(int unsigned ofs);
      longint unsigned mem, nxt_at, pm, after;
      word_type        prev, next, joined;
      if (ofs < HEADER_BYTES) return ST_IGNORED;
      mem = ofs - HEADER_BYTES;
      if (mem >= heap_len) return ST_IGNORED;
      prev = heap_rd(mem + 4);
      next = heap_rd(mem);
      nxt_at = mem + next;
      if (prev != 0) begin
         if (prev > mem) return ST_CORRUPT;
         pm = mem - prev;
         if (heap_rd(pm) != prev) return ST_CORRUPT;
         if (heap_rd(pm + 8) == 0) begin
            joined = prev + next;
            heap_wr(pm, joined);
            mem = pm;
            next = joined;
            if (nxt_at != heap_len) heap_wr(nxt_at + 4, next);
         end
      end
      if (nxt_at <= mem || nxt_at > heap_len) return ST_CORRUPT;
      if (nxt_at != heap_len) begin
         if (heap_rd(nxt_at + 4) != next) return ST_CORRUPT;
         if (heap_rd(nxt_at + 8) == 0) begin
            joined = next + heap_rd(nxt_at);
            heap_wr(mem, joined);
            after = mem + joined;
            if (after != heap_len) heap_wr(after + 4, joined);
         end
      end
      heap_wr(mem + 8, 0);
      return ST_OK;
   endfunction

   function automatic void heap_locate(int unsigned ofs,
                                       output hsize_type res, output stat_code_type st);
      longint unsigned mem;
      word_type        nx;
      res = 0;
      st = ST_IGNORED;
      if (ofs >= heap_len) return;
      mem = 0;
      while (mem < heap_len) begin
         nx = heap_rd(mem);
         if (nx == 0) break;
         if (ofs >= mem && ofs < mem + nx) begin
            if (ofs - mem < HEADER_BYTES) return;
            res = hsize_type'(mem);
            st = ST_OK;
            return;
         end
         mem += nx;
      end
   endfunction

   function automatic heap_result_type heap_apply(op_type op, hsize_type sz, word_type id,
                                                  offset_type ofs);
      heap_result_type r;
      int              idx[$];
      r.result_offset = 0;
      r.status = ST_IGNORED;
      case (op)
         OP_ALLOC: begin
            heap_alloc(sz, id, r.result_offset, r.status);
            if (r.status == ST_OK && sz != 0) live_offsets.push_back(r.result_offset);
         end
         OP_FREE: begin
            r.status = heap_free(ofs);
            idx = live_offsets.find_first_index(x) with (x == ofs);
            if (idx.size() > 0) live_offsets.delete(idx[0]);
         end
         OP_LOCATE: heap_locate(ofs, r.result_offset, r.status);
         default: ;
      endcase
      return r;
   endfunction

   // request side
   task automatic send_req(op_type op, hsize_type sz, word_type id, offset_type ofs);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid = 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_ch.valid = 1;
      req_ch.op = op;
      req_ch.size = sz;
      req_ch.owner_id = id;
      req_ch.offset = ofs;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
         @(negedge clock);
      end
      pending_results.push_back(heap_apply(op, sz, id, ofs));
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid = 0;
      burst_left = 0;
      while (pending_results.size() > 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_heap_size(int unsigned v);
      drain();
      csr_we = 1;
      csr_wdata = hsize_type'(v);
      @(negedge clock);
      csr_we = 0;
      heap_size_write(v);
      live_offsets.delete();
      repeat (5) @(negedge clock);
   endtask

   task automatic send_random_item();
      int unsigned pick, sz;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         case ($urandom_range(0, 19))
            0: sz = $urandom_range(0, 65536);
            1, 2: sz = $urandom_range(0, 4096);
            default: sz = $urandom_range(0, 256);
         endcase
         send_req(OP_ALLOC, hsize_type'(sz), ($urandom_range(0, 30) == 0) ? 0 : $urandom(),
                  offset_type'($urandom_range(0, 65535)));
      end else if (pick < 80 && live_offsets.size() > 0) begin
         send_req(OP_FREE, hsize_type'($urandom_range(0, 131071)), $urandom(),
                  offset_type'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]));
      end else if (pick < 84) begin
         send_req(OP_FREE, hsize_type'($urandom_range(0, 131071)), $urandom(),
                  offset_type'($urandom_range(0, 65535)));
      end else if (pick < 98) begin
         send_req(OP_LOCATE, hsize_type'($urandom_range(0, 131071)), $urandom(),
                  offset_type'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, heap_len - 1)));
      end else begin
         send_req(OP_UNDEF, hsize_type'($urandom_range(0, 131071)), $urandom(),
                  offset_type'($urandom_range(0, 65535)));
      end
   endtask

   // response side
   initial begin
      int stall_timer;
      rsp_ch.ready = 0;
      stall_timer = 0;
      forever begin
         @(negedge clock);
         if (stall_timer == 0) begin
            stall_mode = ~stall_mode;
            stall_timer = $urandom_range(50, 300);
         end
         stall_timer--;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready = 0;
         end else begin
            rsp_ch.ready = stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      heap_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction offset=%0d status=%0d", $time,
                     rsp_ch.result_offset, rsp_ch.status);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_ch.result_offset !== exp_r.result_offset) begin
               $display("%0t: result_offset expected %0d actual %0d", $time,
                        exp_r.result_offset, rsp_ch.result_offset);
               error_count++;
            end
            if (rsp_ch.status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_r.status, rsp_ch.status);
               error_count++;
            end
         end
      end
   end

   // tests
   task automatic test_directed();
      send_req(OP_ALLOC, 0, 32'h1, 0);
      send_req(OP_ALLOC, 17'd65536, 32'hffff_ffff, 16'hffff);
      send_req(OP_ALLOC, 100, 0, 0);
      send_req(OP_ALLOC, 1, 32'hffff_ffff, 0);
      send_req(OP_ALLOC, 100, 32'h1234_5678, 0);
      send_req(OP_ALLOC, 65000, 32'h5, 0);
      send_req(OP_ALLOC, 33, 32'h7, 0);
      send_req(OP_LOCATE, 0, 0, 0);
      send_req(OP_LOCATE, 0, 0, 12);
      send_req(OP_LOCATE, 0, 0, 30);
      send_req(OP_LOCATE, 0, 0, 16'hffff);
      send_req(OP_FREE, 0, 0, 0);
      send_req(OP_FREE, 0, 0, 11);
      send_req(OP_FREE, 0, 0, 16'hffff);
      send_req(OP_FREE, 0, 0, 12);
      send_req(OP_FREE, 0, 0, 12);
      send_req(OP_ALLOC, 8, 32'h9, 0);
      send_req(OP_FREE, 0, 0, 200);
      send_req(OP_FREE, 0, 0, 36);
      send_req(OP_UNDEF, 17'h1ffff, 32'hffff_ffff, 16'hffff);
      send_req(OP_ALLOC, 200, 32'ha, 0);
      send_req(OP_LOCATE, 0, 0, 100);
   endtask

   task automatic test_config();
      int unsigned sizes[6] = '{4096, 131071, 100, 10002, 8192, 65536};
      foreach (sizes[i]) begin
         write_heap_size(sizes[i]);
         repeat (12) send_random_item();
         send_req(OP_ALLOC, hsize_type'(heap_len - HEADER_BYTES), 32'h3, 0);
         send_req(OP_LOCATE, 0, 0, offset_type'(heap_len - 1));
      end
   endtask

   task automatic test_backpressure();
      write_heap_size(8192);
      hold_cycles = 600;
      repeat (30) send_random_item();
   endtask

   task automatic test_random();
      for (int i = 0; i < 760; i++) begin
         if (i % 150 == 149) write_heap_size($urandom_range(0, 16) == 0 ? 65536
                                             : $urandom_range(4096, 65536));
         send_random_item();
      end
   endtask

   initial begin
      reset = 1;
      csr_we = 0;
      csr_wdata = 0;
      req_ch.valid = 0;
      req_ch.op = OP_ALLOC;
      req_ch.size = 0;
      req_ch.owner_id = 0;
      req_ch.offset = 0;
      foreach (heap_mem[i]) heap_mem[i] = 0;
      heap_len = HEAP_BYTES;
      heap_rebuild();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_config();
      test_backpressure();
      test_random();
      drain();
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
